>>> hw/rtl/ppsb_pkg.sv
`timescale 1ns / 1ps

package ppsb_pkg;

	// Sample width of one ADC slice.
	localparam int SAMPLE_W = 10;
	localparam int COEF_W = 4;
	localparam int THR_W = 10;
	localparam int NUM_SLICES = 5;
	localparam int IDX_W = 3;
	// Three products of SAMPLE_W + COEF_W bits need two more bits for the sum.
	localparam int FIR_W = SAMPLE_W + COEF_W + 2;
	localparam int PEAK_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [IDX_W-1:0] NONE_SLICE = IDX_W'(5);
	localparam logic [IDX_W-1:0] NONE_BCID = IDX_W'(6);
	localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LEVEL = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NEXT = CFG_IDX_W'(5);

	// Reset values of the registers.
	localparam logic [THR_W-1:0] RST_LOW_THRESHOLD = THR_W'(255);
	localparam logic [THR_W-1:0] RST_HIGH_THRESHOLD = THR_W'(767);
	localparam logic [THR_W-1:0] RST_SATURATION_LEVEL = THR_W'(1023);
	localparam logic [COEF_W-1:0] RST_COEF_PREV = COEF_W'(7);
	localparam logic [COEF_W-1:0] RST_COEF_MID = COEF_W'(15);
	localparam logic [COEF_W-1:0] RST_COEF_NEXT = COEF_W'(10);

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t slice_0;
		sample_t slice_1;
		sample_t slice_2;
		sample_t slice_3;
		sample_t slice_4;
	} pulse_t;

	typedef struct packed {
		logic [IDX_W-1:0]  peak_slice;
		logic [PEAK_W-1:0] peak_value;
		logic [IDX_W-1:0]  first_low_slice;
		logic [IDX_W-1:0]  first_high_slice;
		logic [IDX_W-1:0]  first_saturated_slice;
		logic [IDX_W-1:0]  saturated_bcid_slice;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0]  low_threshold;
		logic [THR_W-1:0]  high_threshold;
		logic [THR_W-1:0]  saturation_level;
		logic [COEF_W-1:0] coef_prev;
		logic [COEF_W-1:0] coef_mid;
		logic [COEF_W-1:0] coef_next;
	} cfg_t;

	// What one lane found for its slice.
	typedef struct packed {
		logic [FIR_W-1:0] fir;
		logic             above_low;
		logic             above_high;
		logic             saturated;
	} lane_t;

endpackage

>>> hw/rtl/ppsb_lane.sv
`timescale 1ns / 1ps

module ppsb_lane
	import ppsb_pkg::*;
(
	input  logic    clk,
	input  logic    load,
	input  cfg_t    cfg,
	input  sample_t prev_sample,
	input  sample_t cur_sample,
	input  sample_t next_sample,
	output lane_t   lane_s1
);

	logic [FIR_W-1:0] prod_prev;
	logic [FIR_W-1:0] prod_mid;
	logic [FIR_W-1:0] prod_next;
	lane_t            lane_d;

	// Neighbors outside the window arrive as zero, so every lane is the same.
	assign prod_prev = FIR_W'(prev_sample) * FIR_W'(cfg.coef_prev);
	assign prod_mid = FIR_W'(cur_sample) * FIR_W'(cfg.coef_mid);
	assign prod_next = FIR_W'(next_sample) * FIR_W'(cfg.coef_next);

	always_comb begin
		lane_d.fir = prod_prev + prod_mid + prod_next;
		lane_d.above_low = cur_sample > cfg.low_threshold;
		lane_d.above_high = cur_sample > cfg.high_threshold;
		lane_d.saturated = cur_sample >= cfg.saturation_level;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_s1 <= lane_d;
		end
	end

endmodule

>>> hw/rtl/ppsb_merge.sv
`timescale 1ns / 1ps

module ppsb_merge
	import ppsb_pkg::*;
(
	input  logic    clk,
	input  logic    load,
	input  lane_t   lanes [NUM_SLICES],
	output result_t result_s2
);

	logic [IDX_W-1:0] pk;
	logic [FIR_W-1:0] pk_val;
	logic [IDX_W-1:0] lo;
	logic [IDX_W-1:0] hi;
	logic [IDX_W-1:0] sat;
	logic [IDX_W-1:0] bcid;
	result_t          res_d;

	// Earliest strict maximum above zero, and the first crossing of each level.
	always_comb begin
		pk = NONE_SLICE;
		pk_val = '0;
		lo = NONE_SLICE;
		hi = NONE_SLICE;
		sat = NONE_SLICE;
		for (int i = 0; i < NUM_SLICES; i++) begin
			if (lanes[i].fir > pk_val) begin
				pk = IDX_W'(i);
				pk_val = lanes[i].fir;
			end
			if (lanes[i].above_low && lo == NONE_SLICE) begin
				lo = IDX_W'(i);
			end
			if (lanes[i].above_high && hi == NONE_SLICE) begin
				hi = IDX_W'(i);
			end
			if (lanes[i].saturated && sat == NONE_SLICE) begin
				sat = IDX_W'(i);
			end
		end
	end

	// Saturated-pulse decision from the first saturated, high and low slices.
	always_comb begin
		bcid = NONE_BCID;
		if (sat != NONE_SLICE) begin
			if (hi == sat) begin
				bcid = sat + IDX_W'(1);
			end else if (sat != '0 && hi == sat - IDX_W'(1)) begin
				if (hi != '0 && lo == hi - IDX_W'(1)) begin
					bcid = sat;
				end else if (lo == hi) begin
					bcid = sat + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		res_d.peak_slice = pk;
		res_d.peak_value = (pk_val > FIR_W'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(pk_val);
		res_d.first_low_slice = lo;
		res_d.first_high_slice = hi;
		res_d.first_saturated_slice = sat;
		res_d.saturated_bcid_slice = bcid;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= res_d;
		end
	end

endmodule

>>> hw/rtl/pulse_peak_and_saturation_bcid.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// pulse     in   pulse_valid / pulse_stall  pulse_t: slices 0 to 4
// result    out  result_valid / result_stall result_t: peak and crossing slices
// cfg       in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One pulse beat can be taken every cycle while pulse_stall is low. The five
// filter lanes register the sums and flags of a pulse, then the merge stage
// registers the combined result. The output register holds a stalled result
// while the lane stage still takes one more pulse. Reset restores every config
// register to its documented value and empties the pipeline; cfg_ready is always high.

module pulse_peak_and_saturation_bcid
	import ppsb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pulse_valid,
	output logic                  pulse_stall,
	input  pulse_t                pulse,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    valid_s2;
	logic    out_free;
	logic    load_s1;
	logic    load_s2;
	sample_t samples [NUM_SLICES+2];
	lane_t   lanes [NUM_SLICES];

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold <= RST_LOW_THRESHOLD;
			cfg_q.high_threshold <= RST_HIGH_THRESHOLD;
			cfg_q.saturation_level <= RST_SATURATION_LEVEL;
			cfg_q.coef_prev <= RST_COEF_PREV;
			cfg_q.coef_mid <= RST_COEF_MID;
			cfg_q.coef_next <= RST_COEF_NEXT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_THRESHOLD:    cfg_q.low_threshold <= THR_W'(cfg_data);
				REG_HIGH_THRESHOLD:   cfg_q.high_threshold <= THR_W'(cfg_data);
				REG_SATURATION_LEVEL: cfg_q.saturation_level <= THR_W'(cfg_data);
				REG_COEF_PREV:        cfg_q.coef_prev <= cfg_data[COEF_W-1:0];
				REG_COEF_MID:         cfg_q.coef_mid <= cfg_data[COEF_W-1:0];
				REG_COEF_NEXT:        cfg_q.coef_next <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The output register can take a new result when it is empty or being read.
	// The lane stage moves on whenever its contents can go forward, so a pulse is
	// refused only when both stages are full and the output is stalled.
	assign out_free = !valid_s2 || !result_stall;
	assign load_s2 = valid_s1 && out_free;
	assign pulse_stall = valid_s1 && !out_free;
	assign load_s1 = pulse_valid && !pulse_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// The window is padded with a zero sample on each side, so slice 0 sees no
	// preceding tap and slice 4 no following tap.
	always_comb begin
		samples[0] = '0;
		samples[1] = pulse.slice_0;
		samples[2] = pulse.slice_1;
		samples[3] = pulse.slice_2;
		samples[4] = pulse.slice_3;
		samples[5] = pulse.slice_4;
		samples[NUM_SLICES+1] = '0;
	end

	// One filter lane per slice.
	for (genvar g = 0; g < NUM_SLICES; g++) begin : g_lane
		ppsb_lane u_lane (
			.clk         (clk),
			.load        (load_s1),
			.cfg         (cfg_q),
			.prev_sample (samples[g]),
			.cur_sample  (samples[g+1]),
			.next_sample (samples[g+2]),
			.lane_s1     (lanes[g])
		);
	end

	// The merge stage picks the peak and decides the crossing slice.
	ppsb_merge u_merge (
		.clk       (clk),
		.load      (load_s2),
		.lanes     (lanes),
		.result_s2 (result)
	);

	assign result_valid = valid_s2;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the pulse peak finder and saturated BCID block.
// Pulses are queued by the stimulus process, sent by a clocked driver and
// predicted at the edge where the block takes them. A clocked watcher then
// compares every returned beat with the oldest prediction.
module tb_top;
	import ppsb_pkg::*;

	// Index codes that the block has no register for; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

	// How long each side waits between beats during a stretch of traffic.
	typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_SPARSE} idle_e;

	// Amplitude bands relative to the current thresholds, used to build pulses
	// that climb through the low, high and saturated regions in various steps.
	typedef enum int {BAND_QUIET, BAND_LOW, BAND_HIGH, BAND_SAT} band_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pulse_valid = 1'b0;
	logic                  pulse_stall;
	pulse_t                pulse = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Our own copy of the register file, updated when a write beat is taken.
	cfg_t    model_cfg;
	// Pulses waiting to be driven, and results owed by the block in order.
	pulse_t  pulse_backlog[$];
	result_t awaited_results[$];

	idle_e   src_mode = IDLE_NONE;
	idle_e   sink_mode = IDLE_NONE;
	int      src_gap = 0;
	int      sink_wait = 0;

	int      fail_count = 0;
	int      pulses_sent = 0;
	int      results_seen = 0;
	int      decided_count = 0;
	int      no_peak_count = 0;
	int      settings_count = 0;

	pulse_peak_and_saturation_bcid u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pulse_valid  (pulse_valid),
		.pulse_stall  (pulse_stall),
		.pulse        (pulse),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicts the result beat for one pulse under the current register copy.
	// Each slice gets a three-tap filter sum with missing neighbors counted as
	// zero; the peak is the earliest strict maximum above zero. The crossing
	// slice follows from where the first saturated, high and low slices sit.
	function automatic result_t compute_bcid_result(pulse_t p);
		sample_t     s[NUM_SLICES];
		int unsigned fir;
		int unsigned best;
		int          lo;
		int          hi;
		int          sat;
		int          pk;
		int          bcid;
		int          i;
		result_t     r;
		s[0] = p.slice_0;
		s[1] = p.slice_1;
		s[2] = p.slice_2;
		s[3] = p.slice_3;
		s[4] = p.slice_4;
		lo = NONE_SLICE;
		hi = NONE_SLICE;
		sat = NONE_SLICE;
		pk = NONE_SLICE;
		bcid = NONE_BCID;
		best = 0;
		for (i = 0; i < NUM_SLICES; i++) begin
			fir = s[i] * model_cfg.coef_mid;
			if (i > 0)
				fir += s[i-1] * model_cfg.coef_prev;
			if (i < NUM_SLICES - 1)
				fir += s[i+1] * model_cfg.coef_next;
			if (s[i] > model_cfg.low_threshold && lo == NONE_SLICE)
				lo = i;
			if (s[i] > model_cfg.high_threshold && hi == NONE_SLICE)
				hi = i;
			if (s[i] >= model_cfg.saturation_level && sat == NONE_SLICE)
				sat = i;
			if (fir > best) begin
				pk = i;
				best = fir;
			end
		end
		if (sat != NONE_SLICE) begin
			// High crossing on the saturated slice itself: the pulse rose
			// fast, so the crossing is taken one slice later.
			if (hi == sat) begin
				bcid = sat + 1;
			end else if (sat >= 1 && hi == sat - 1) begin
				// A clean staircase low, high, saturated points at the
				// saturated slice; low and high together point one later.
				if (hi >= 1 && lo == hi - 1)
					bcid = sat;
				else if (lo == hi)
					bcid = sat + 1;
			end
		end
		r.peak_slice = IDX_W'(pk);
		r.peak_value = (best > 32'hFFFF) ? PEAK_MAX : best[PEAK_W-1:0];
		r.first_low_slice = IDX_W'(lo);
		r.first_high_slice = IDX_W'(hi);
		r.first_saturated_slice = IDX_W'(sat);
		r.saturated_bcid_slice = IDX_W'(bcid);
		return r;
	endfunction

	function automatic int draw_wait(idle_e mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_RANDOM: return $urandom_range(15, 0);
			default: return ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : 0;
		endcase
	endfunction

	// Picks a sample inside one band of the current thresholds. Odd register
	// settings can leave a band empty, and then any sample will do.
	function automatic sample_t band_sample(band_e band);
		int lo_b;
		int hi_b;
		case (band)
			BAND_QUIET: begin
				lo_b = 0;
				hi_b = model_cfg.low_threshold;
			end
			BAND_LOW: begin
				lo_b = model_cfg.low_threshold + 1;
				hi_b = model_cfg.high_threshold;
			end
			BAND_HIGH: begin
				lo_b = model_cfg.high_threshold + 1;
				hi_b = int'(model_cfg.saturation_level) - 1;
			end
			default: begin
				lo_b = model_cfg.saturation_level;
				hi_b = 1023;
			end
		endcase
		if (lo_b > hi_b || hi_b > 1023)
			return sample_t'($urandom_range(1023, 0));
		return sample_t'($urandom_range(hi_b, lo_b));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Driver. The payload only moves when the current beat has been taken or
	// nothing is on the bus, so a stalled beat stays put. The prediction is
	// made at the accepting edge, with the registers as they are then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_valid <= 1'b0;
			pulse <= '0;
			src_gap <= 0;
		end else begin
			if (pulse_valid && !pulse_stall) begin
				awaited_results.push_back(compute_bcid_result(pulse));
				pulses_sent++;
			end
			if (!pulse_valid || !pulse_stall) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					pulse_valid <= 1'b0;
				end else if (pulse_backlog.size() > 0) begin
					pulse <= pulse_backlog.pop_front();
					pulse_valid <= 1'b1;
					src_gap <= draw_wait(src_mode);
				end else begin
					pulse_valid <= 1'b0;
				end
			end
		end
	end

	// Result watcher. After every taken beat it draws how many cycles to
	// stall; the countdown runs whether or not a result is waiting, so the
	// stalls land on every stage of the pipeline.
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t want;
		int      w;
		if (!arst_n) begin
			result_stall <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no pulse outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("peak_slice", want.peak_slice, result.peak_slice);
					check_field("peak_value", want.peak_value, result.peak_value);
					check_field("first_low_slice", want.first_low_slice,
						result.first_low_slice);
					check_field("first_high_slice", want.first_high_slice,
						result.first_high_slice);
					check_field("first_saturated_slice", want.first_saturated_slice,
						result.first_saturated_slice);
					check_field("saturated_bcid_slice", want.saturated_bcid_slice,
						result.saturated_bcid_slice);
					results_seen++;
					if (want.saturated_bcid_slice != NONE_BCID)
						decided_count++;
					if (want.peak_slice == NONE_SLICE)
						no_peak_count++;
				end
				w = draw_wait(sink_mode);
				sink_wait <= w;
				result_stall <= (w != 0);
			end else if (sink_wait > 0) begin
				sink_wait <= sink_wait - 1;
				result_stall <= (sink_wait > 1);
			end
		end
	end

	// One register write. Valid rises at an edge and drops at the edge where
	// the write is taken; the register copy changes at that same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_LOW_THRESHOLD: model_cfg.low_threshold = data;
			REG_HIGH_THRESHOLD: model_cfg.high_threshold = data;
			REG_SATURATION_LEVEL: model_cfg.saturation_level = data;
			REG_COEF_PREV: model_cfg.coef_prev = data[COEF_W-1:0];
			REG_COEF_MID: model_cfg.coef_mid = data[COEF_W-1:0];
			REG_COEF_NEXT: model_cfg.coef_next = data[COEF_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Writes all six registers. Coefficients go out with random junk above
	// their four bits, which the block has to drop.
	task automatic apply_setting(input cfg_t s);
		write_reg(REG_LOW_THRESHOLD, s.low_threshold);
		write_reg(REG_HIGH_THRESHOLD, s.high_threshold);
		write_reg(REG_SATURATION_LEVEL, s.saturation_level);
		write_reg(REG_COEF_PREV, {(CFG_DATA_W-COEF_W)'($urandom), s.coef_prev});
		write_reg(REG_COEF_MID, {(CFG_DATA_W-COEF_W)'($urandom), s.coef_mid});
		write_reg(REG_COEF_NEXT, {(CFG_DATA_W-COEF_W)'($urandom), s.coef_next});
		settings_count++;
	endtask

	// Thresholds are usually drawn in their natural order, sometimes not.
	task automatic apply_random_setting();
		cfg_t s;
		int   t[3];
		int   tmp;
		int   i;
		int   j;
		for (i = 0; i < 3; i++)
			t[i] = $urandom_range(1023, 0);
		if ($urandom_range(3, 0) != 0) begin
			for (i = 0; i < 2; i++)
				for (j = 0; j < 2 - i; j++)
					if (t[j] > t[j+1]) begin
						tmp = t[j];
						t[j] = t[j+1];
						t[j+1] = tmp;
					end
		end
		s.low_threshold = THR_W'(t[0]);
		s.high_threshold = THR_W'(t[1]);
		s.saturation_level = THR_W'(t[2]);
		s.coef_prev = COEF_W'($urandom);
		s.coef_mid = COEF_W'($urandom);
		s.coef_next = COEF_W'($urandom);
		apply_setting(s);
	endtask

	task automatic push_pulse(input sample_t a, input sample_t b, input sample_t c,
			input sample_t d, input sample_t e);
		pulse_backlog.push_back(pulse_t'({a, b, c, d, e}));
	endtask

	// Blocks until the driver has nothing left and every result is back.
	task automatic wait_drained();
		do @(posedge clk);
		while (pulse_backlog.size() != 0 || pulse_valid || awaited_results.size() != 0);
	endtask

	// Corner pulses worth repeating under every register setting: silence,
	// full scale, lone spikes on the first and last slices and a flat plateau.
	task automatic push_corner_pulses();
		push_pulse(0, 0, 0, 0, 0);
		push_pulse(1023, 1023, 1023, 1023, 1023);
		push_pulse(1023, 0, 0, 0, 0);
		push_pulse(0, 0, 0, 0, 1023);
		push_pulse(512, 512, 512, 512, 512);
	endtask

	// Most random pulses climb from quiet through the threshold bands in
	// steps of zero to three bands, which walks through every crossing rule.
	// The rest are plain noise, near-flat pulses that force filter ties, and
	// pulses built from full-scale and near-zero samples.
	task automatic push_random_pulses(input int count);
		sample_t s[NUM_SLICES];
		int      kind;
		int      rise;
		int      b;
		int      step;
		int      i;
		int      n;
		sample_t v;
		for (n = 0; n < count; n++) begin
			kind = $urandom_range(9, 0);
			rise = $urandom_range(4, 0);
			b = BAND_QUIET;
			v = sample_t'($urandom_range(1023, 0));
			for (i = 0; i < NUM_SLICES; i++) begin
				if (kind < 6) begin
					if (b == BAND_SAT && $urandom_range(2, 0) == 0)
						b = $urandom_range(2, 0);
					else if (i >= rise) begin
						step = $urandom_range(3, 0);
						b = (b + step > BAND_SAT) ? BAND_SAT : b + step;
					end
					s[i] = band_sample(band_e'(b));
				end else if (kind < 8) begin
					s[i] = sample_t'($urandom_range(1023, 0));
				end else if (kind == 8) begin
					s[i] = ($urandom_range(1, 0) == 0) ? v : v ^ sample_t'(1);
				end else begin
					case ($urandom_range(3, 0))
						0: s[i] = '0;
						1: s[i] = '1;
						2: s[i] = sample_t'(1);
						default: s[i] = sample_t'(1022);
					endcase
				end
			end
			push_pulse(s[0], s[1], s[2], s[3], s[4]);
		end
	endtask

	// A phase of random traffic under one setting. Halfway through, the
	// sender holds back until every outstanding result has returned.
	task automatic run_phase(input int count);
		src_mode = idle_e'($urandom_range(2, 0));
		sink_mode = idle_e'($urandom_range(2, 0));
		push_corner_pulses();
		push_random_pulses(count / 2);
		wait_drained();
		src_mode = idle_e'($urandom_range(2, 0));
		sink_mode = idle_e'($urandom_range(2, 0));
		push_random_pulses(count - count / 2);
		wait_drained();
	endtask

	initial begin : stimulus
		int k;
		model_cfg.low_threshold = RST_LOW_THRESHOLD;
		model_cfg.high_threshold = RST_HIGH_THRESHOLD;
		model_cfg.saturation_level = RST_SATURATION_LEVEL;
		model_cfg.coef_prev = RST_COEF_PREV;
		model_cfg.coef_mid = RST_COEF_MID;
		model_cfg.coef_next = RST_COEF_NEXT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pulses under the reset registers, sent back to back.
		push_corner_pulses();
		push_pulse(0, 1023, 0, 0, 0);
		push_pulse(0, 0, 1023, 0, 0);
		push_pulse(0, 0, 0, 1023, 0);
		// Low, high, saturated on consecutive slices: crossing on slice 2.
		push_pulse(300, 800, 1023, 1023, 1023);
		// Low and high together, then saturated: crossing one slice late.
		push_pulse(0, 800, 1023, 600, 0);
		// The staircase at the end of the window.
		push_pulse(0, 0, 300, 800, 1023);
		// Low crossing too early for the staircase: no crossing decided.
		push_pulse(300, 300, 800, 1023, 900);
		// Samples one above each threshold, and one sample exactly saturated.
		push_pulse(255, 256, 767, 768, 1023);
		// Saturated and high on slice 0 of a falling pulse.
		push_pulse(1023, 800, 300, 0, 0);
		push_pulse(10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA);
		push_pulse(10'h155, 10'h155, 10'h155, 10'h155, 10'h155);
		push_pulse(1, 0, 0, 0, 0);
		push_pulse(0, 0, 0, 0, 1);
		push_pulse(1022, 1022, 1022, 1022, 1022);
		push_pulse(100, 0, 100, 0, 100);
		wait_drained();

		src_mode = IDLE_RANDOM;
		sink_mode = IDLE_RANDOM;
		push_random_pulses(75);
		wait_drained();
		src_mode = IDLE_SPARSE;
		sink_mode = IDLE_NONE;
		push_random_pulses(75);
		wait_drained();

		// Everything at zero: no filter output at all, and slice 0 always
		// counts as saturated. The spare indexes go out here too.
		apply_setting(cfg_t'{10'd0, 10'd0, 10'd0, 4'd0, 4'd0, 4'd0});
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		run_phase(100);

		// Everything at full scale: no sample can exceed the thresholds of 1023, but 1023 saturates.
		apply_setting(cfg_t'{10'd1023, 10'd1023, 10'd1023, 4'd15, 4'd15, 4'd15});
		run_phase(100);

		// Thresholds out of order and a lopsided filter.
		apply_setting(cfg_t'{10'd900, 10'd100, 10'd300, 4'd15, 4'd0, 4'd1});
		run_phase(150);

		for (k = 0; k < 6; k++) begin
			apply_random_setting();
			run_phase(150);
		end

		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			fail_count++;
		end
		$display("Checked %0d of %0d pulses across %0d register settings.",
			results_seen, pulses_sent, settings_count + 1);
		$display("%0d pulses decided a saturated crossing; %0d had no filter peak.",
			decided_count, no_peak_count);
		if (fail_count == 0)
			$display("[pulse_peak_and_saturation_bcid] OK");
		else
			$display("[pulse_peak_and_saturation_bcid] ERROR");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("[pulse_peak_and_saturation_bcid] ERROR");
		$finish;
	end

endmodule
